[rtl/core/wcg_pkg.sv]
package wcg_pkg;

    localparam int MAX_LENGTH     = 4096;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_W         = COEF_FRAC_BITS + 2;
    localparam int TYPE_W         = 4;
    localparam int LEN_W          = 13;
    localparam int IDX_W          = 12;
    localparam int CSUM_W         = 30;
    localparam int SSUM_W         = 45;
    localparam int FACT_W         = 32;
    localparam int CFG_W          = 13;

    localparam int DIV_NW         = 50;
    localparam int DIV_DW         = 45;
    localparam int DIV_CW         = 6;

    localparam int CORD_W         = 34;
    localparam int CORD_ZW        = 33;
    localparam int CORD_STEPS     = 28;
    localparam int CORD_SW        = 5;

    localparam int ACC_W          = 36;
    localparam int PROD_W         = 2 * CORD_W;
    localparam int Q_SHIFT        = 30 - COEF_FRAC_BITS;
    localparam int AMP_EXP        = COEF_FRAC_BITS + 17;
    localparam int ENG_EXP        = 2 * COEF_FRAC_BITS + 17;

    localparam logic [TYPE_W-1:0] WT_BARTHANN  = 4'd0;
    localparam logic [TYPE_W-1:0] WT_BARTLETT  = 4'd1;
    localparam logic [TYPE_W-1:0] WT_BLACKMAN  = 4'd2;
    localparam logic [TYPE_W-1:0] WT_BHARRIS   = 4'd3;
    localparam logic [TYPE_W-1:0] WT_BOHMAN    = 4'd4;
    localparam logic [TYPE_W-1:0] WT_FLATTOP   = 4'd5;
    localparam logic [TYPE_W-1:0] WT_HAMMING   = 4'd6;
    localparam logic [TYPE_W-1:0] WT_HANN      = 4'd7;
    localparam logic [TYPE_W-1:0] WT_NUTTALL   = 4'd8;
    localparam logic [TYPE_W-1:0] WT_RECT      = 4'd9;
    localparam logic [TYPE_W-1:0] WT_TRIANG    = 4'd10;

    localparam logic CFG_TYPE   = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    localparam logic [CORD_W-1:0] BOHMAN_SIN_C = 34'd341782638;
    localparam logic [CORD_W-1:0] BARTHANN_LIN = 34'd515396076;

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_COSK, S_DIVW, S_CORW, S_MUL, S_ACC,
        S_ROUND, S_SQ, S_SUM, S_CHK, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        P_DIRECT, P_LIN, P_BPH, P_PH, P_AMP, P_ENG
    } t_dpurp;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic        start;
        logic [31:0] phase;
    } t_cord_req;

    typedef struct packed {
        logic              done;
        logic [CORD_W-1:0] cosv;
        logic [CORD_W-1:0] sinv;
    } t_cord_rsp;

    function automatic logic [29:0] atan_turn(input logic [CORD_SW-1:0] i);
        case (i)
            5'd0:  atan_turn = 30'd536870912;
            5'd1:  atan_turn = 30'd316933406;
            5'd2:  atan_turn = 30'd167458907;
            5'd3:  atan_turn = 30'd85004756;
            5'd4:  atan_turn = 30'd42667331;
            5'd5:  atan_turn = 30'd21354465;
            5'd6:  atan_turn = 30'd10679838;
            5'd7:  atan_turn = 30'd5340245;
            5'd8:  atan_turn = 30'd2670163;
            5'd9:  atan_turn = 30'd1335087;
            5'd10: atan_turn = 30'd667544;
            5'd11: atan_turn = 30'd333772;
            5'd12: atan_turn = 30'd166886;
            5'd13: atan_turn = 30'd83443;
            5'd14: atan_turn = 30'd41722;
            5'd15: atan_turn = 30'd20861;
            5'd16: atan_turn = 30'd10430;
            5'd17: atan_turn = 30'd5215;
            5'd18: atan_turn = 30'd2608;
            5'd19: atan_turn = 30'd1304;
            5'd20: atan_turn = 30'd652;
            5'd21: atan_turn = 30'd326;
            5'd22: atan_turn = 30'd163;
            5'd23: atan_turn = 30'd81;
            5'd24: atan_turn = 30'd41;
            5'd25: atan_turn = 30'd20;
            5'd26: atan_turn = 30'd10;
            5'd27: atan_turn = 30'd5;
            default: atan_turn = 30'd0;
        endcase
    endfunction

    // Q30 constant term
    function automatic logic [ACC_W-1:0] win_base(input logic [TYPE_W-1:0] t);
        case (t)
            WT_BARTHANN: win_base = 36'd665719931;
            WT_BLACKMAN: win_base = 36'd450971566;
            WT_BHARRIS:  win_base = 36'd385204879;
            WT_FLATTOP:  win_base = 36'd231476135;
            WT_HAMMING:  win_base = 36'd579820585;
            WT_HANN:     win_base = 36'd536870912;
            WT_NUTTALL:  win_base = 36'd390393092;
            WT_RECT:     win_base = 36'd1073741824;
            default:     win_base = 36'd0;
        endcase
    endfunction

    function automatic logic [2:0] win_terms(input logic [TYPE_W-1:0] t);
        case (t)
            WT_BARTHANN: win_terms = 3'd1;
            WT_BLACKMAN: win_terms = 3'd2;
            WT_BHARRIS:  win_terms = 3'd3;
            WT_FLATTOP:  win_terms = 3'd4;
            WT_HAMMING:  win_terms = 3'd1;
            WT_HANN:     win_terms = 3'd1;
            WT_NUTTALL:  win_terms = 3'd3;
            default:     win_terms = 3'd0;
        endcase
    endfunction

    // {subtract, magnitude} of the k-th cosine weight
    function automatic logic [31:0] win_coef(input logic [TYPE_W-1:0] t,
                                             input logic [2:0] k);
        logic [31:0] c;
        c = 32'd0;
        case (t)
            WT_BARTHANN: c = {1'b1, 31'd408021893};
            WT_BLACKMAN: begin
                case (k)
                    3'd1:    c = {1'b1, 31'd536870912};
                    default: c = {1'b0, 31'd85899346};
                endcase
            end
            WT_BHARRIS: begin
                case (k)
                    3'd1:    c = {1'b1, 31'd524297395};
                    3'd2:    c = {1'b0, 31'd151698245};
                    default: c = {1'b1, 31'd12541305};
                endcase
            end
            WT_FLATTOP: begin
                case (k)
                    3'd1:    c = {1'b1, 31'd447354753};
                    3'd2:    c = {1'b0, 31'd297709049};
                    3'd3:    c = {1'b1, 31'd89742211};
                    default: c = {1'b0, 31'd7459680};
                endcase
            end
            WT_HAMMING: c = {1'b1, 31'd493921239};
            WT_HANN:    c = {1'b1, 31'd536870912};
            WT_NUTTALL: begin
                case (k)
                    3'd1:    c = {1'b1, 31'd525250341};
                    3'd2:    c = {1'b0, 31'd146672596};
                    default: c = {1'b1, 31'd11425794};
                endcase
            end
            default: c = 32'd0;
        endcase
        win_coef = c;
    endfunction

endpackage

[rtl/core/wcg_div.sv]
module wcg_div
    import wcg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW:0]   r_rem;
    logic [DIV_DW-1:0] r_den;

    logic [DIV_DW:0]   w_try;
    logic              w_ge;

    assign w_try = {r_rem[DIV_DW-1:0], r_num[DIV_NW-1]};
    assign w_ge  = (w_try >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_try - {1'b0, r_den}) : w_try;
                r_quo <= {r_quo[DIV_NW-2:0], w_ge};
                r_num <= {r_num[DIV_NW-2:0], 1'b0};
                r_cnt <= r_cnt + DIV_CW'(1);
                if (r_cnt == DIV_CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

[rtl/core/wcg_cordic.sv]
module wcg_cordic
    import wcg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cord_req i_req,
    output t_cord_rsp o_rsp
);

    logic                      r_busy;
    logic                      r_done;
    logic                      r_neg;
    logic [CORD_SW-1:0]        r_i;
    logic signed [CORD_W-1:0]  r_x;
    logic signed [CORD_W-1:0]  r_y;
    logic signed [CORD_ZW-1:0] r_z;

    logic signed [CORD_W-1:0]  w_dx;
    logic signed [CORD_W-1:0]  w_dy;
    logic signed [CORD_ZW-1:0] w_at;
    logic [CORD_ZW-1:0]        w_z0;
    logic                      w_neg0;

    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign w_at = $signed({3'b000, atan_turn(r_i)});

    // fold the phase into the right half plane
    always_comb begin
        w_neg0 = 1'b0;
        w_z0   = {1'b0, i_req.phase};
        case (i_req.phase[31:30])
            2'b01, 2'b10: begin
                w_z0   = {1'b0, i_req.phase} - 33'h080000000;
                w_neg0 = 1'b1;
            end
            2'b11:   w_z0 = {1'b0, i_req.phase} - 33'h100000000;
            default: w_z0 = {1'b0, i_req.phase};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_x    <= 34'sd652032875;
                r_y    <= '0;
                r_z    <= $signed(w_z0);
                r_neg  <= w_neg0;
            end else if (r_busy) begin
                if (!r_z[CORD_ZW-1]) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_at;
                end
                r_i <= r_i + CORD_SW'(1);
                if (r_i == CORD_SW'(CORD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.cosv = r_neg ? -r_x : r_x;
    assign o_rsp.sinv = r_neg ? -r_y : r_y;

endmodule

[rtl/core/window_coefficient_generator.sv]
// Channel  | Direction | Handshake          | Payload
// input    | in        | i_valid / o_ready  | i_restart
// output   | out       | o_valid / i_ready  | o_coefficient, o_sample_index, o_last_sample,
//          |           |                    | o_amplitude_factor, o_energy_factor, o_zero_sum
// config   | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One transaction at a time; o_ready is high only while idle.
// Each cosine term uses the shared divider for the phase, the 28-step CORDIC and a MAC;
// the last sample adds two divides, for the amplitude and energy factors, unless o_zero_sum is set.
// Reset is synchronous, active low: registers return to type 9, length 256, counter 0.
// A stalled output holds its register; the next input is taken meanwhile and waits at the end.
module window_coefficient_generator
    import wcg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_restart,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [COEF_W-1:0] o_coefficient,
    output logic [IDX_W-1:0]         o_sample_index,
    output logic                     o_last_sample,
    output logic [FACT_W-1:0]        o_amplitude_factor,
    output logic [FACT_W-1:0]        o_energy_factor,
    output logic                     o_zero_sum,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    t_state r_state, n_state;
    t_dpurp r_purp;

    logic [TYPE_W-1:0]         r_wtype;
    logic [LEN_W-1:0]          r_wlen;
    logic [IDX_W-1:0]          r_cnt;
    logic [CSUM_W-1:0]         r_csum;
    logic [SSUM_W-1:0]         r_ssum;

    logic [IDX_W-1:0]          r_n;
    logic [IDX_W-1:0]          r_nn;
    logic [LEN_W-1:0]          r_ll;
    logic [IDX_W-1:0]          r_d;
    logic [IDX_W-1:0]          r_r;
    logic [2:0]                r_k;
    logic [30:0]               r_a;
    logic                      r_bsin;
    logic                      r_sub;
    logic                      r_last;
    logic signed [CORD_W-1:0]  r_sinv;
    logic signed [CORD_W-1:0]  r_xop;
    logic signed [CORD_W-1:0]  r_cop;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [COEF_W-1:0]  r_coef;
    logic [2*COEF_W-1:0]       r_sq;
    logic [FACT_W-1:0]         r_amp;
    logic [FACT_W-1:0]         r_eng;
    logic                      r_zs;
    logic                      r_ovalid;

    t_div_req  r_dreq;
    t_div_rsp  w_drsp;
    t_cord_req r_creq;
    t_cord_rsp w_crsp;

    logic [LEN_W-1:0]          w_lc;
    logic [IDX_W-1:0]          w_nnc;
    logic [LEN_W-1:0]          w_n2;
    logic [IDX_W-1:0]          w_m;
    logic [IDX_W-1:0]          w_d;
    logic [LEN_W-1:0]          w_rsum;
    logic [IDX_W-1:0]          w_rnew;
    logic signed [PROD_W-1:0]  w_qfull;
    logic signed [ACC_W-1:0]   w_q;
    logic signed [ACC_W-1:0]   w_rnd;
    logic signed [COEF_W-1:0]  w_sat;
    logic signed [2*COEF_W-1:0] w_sqp;
    logic [31:0]               w_wc;
    logic [FACT_W-1:0]         w_qsat;
    logic                      w_cos_type;
    logic                      w_zs;
    logic                      w_room;

    wcg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_dreq),
        .o_rsp   (w_drsp)
    );

    wcg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_creq),
        .o_rsp   (w_crsp)
    );

    always_comb begin
        if (r_wlen < LEN_W'(2)) begin
            w_lc = LEN_W'(2);
        end else if (r_wlen > LEN_W'(MAX_LENGTH)) begin
            w_lc = LEN_W'(MAX_LENGTH);
        end else begin
            w_lc = r_wlen;
        end
    end
    assign w_nnc = IDX_W'(w_lc - LEN_W'(1));

    assign w_n2   = {r_n, 1'b0};
    assign w_m    = (r_n < (r_nn - r_n)) ? r_n : (r_nn - r_n);
    assign w_d    = (w_n2 >= {1'b0, r_nn}) ? IDX_W'(w_n2 - {1'b0, r_nn})
                                           : IDX_W'({1'b0, r_nn} - w_n2);
    assign w_rsum = {1'b0, r_r} + {1'b0, r_n};
    assign w_rnew = (w_rsum >= {1'b0, r_nn}) ? IDX_W'(w_rsum - {1'b0, r_nn})
                                             : IDX_W'(w_rsum);

    assign w_qfull = (r_prod + (PROD_W'(1) <<< 29)) >>> 30;
    assign w_q     = w_qfull[ACC_W-1:0];

    assign w_rnd = (r_acc + (ACC_W'(1) <<< (Q_SHIFT - 1))) >>> Q_SHIFT;
    always_comb begin
        if (w_rnd > $signed(ACC_W'((1 << (COEF_FRAC_BITS + 1)) - 1))) begin
            w_sat = $signed(COEF_W'((1 << (COEF_FRAC_BITS + 1)) - 1));
        end else if (w_rnd < -$signed(ACC_W'(1 << (COEF_FRAC_BITS + 1)))) begin
            w_sat = $signed(COEF_W'(1 << (COEF_FRAC_BITS + 1)));
        end else begin
            w_sat = w_rnd[COEF_W-1:0];
        end
    end

    assign w_sqp      = r_coef * r_coef;
    assign w_wc       = win_coef(r_wtype, r_k);
    assign w_qsat     = (|w_drsp.quo[DIV_NW-1:FACT_W]) ? '1 : w_drsp.quo[FACT_W-1:0];
    assign w_cos_type = (r_wtype inside {WT_BLACKMAN, WT_BHARRIS, WT_FLATTOP,
                                         WT_HAMMING, WT_HANN, WT_NUTTALL});
    assign w_zs       = r_csum[CSUM_W-1] || (r_csum == '0) || (r_ssum == '0);
    assign w_room     = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_SETUP;
            end
            S_SETUP: begin
                if (r_wtype inside {WT_BARTLETT, WT_TRIANG, WT_BARTHANN, WT_BOHMAN}) begin
                    n_state = S_DIVW;
                end else if (w_cos_type) begin
                    n_state = S_COSK;
                end else begin
                    n_state = S_ROUND;
                end
            end
            S_COSK: n_state = S_DIVW;
            S_DIVW: begin
                if (w_drsp.done) begin
                    case (r_purp)
                        P_DIRECT: n_state = S_ROUND;
                        P_LIN:    n_state = (r_wtype == WT_BARTHANN) ? S_MUL : S_DIVW;
                        P_BPH:    n_state = S_CORW;
                        P_PH:     n_state = S_CORW;
                        P_AMP:    n_state = S_DIVW;
                        P_ENG:    n_state = S_DONE;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_CORW: begin
                if (w_crsp.done) n_state = S_MUL;
            end
            S_MUL: n_state = S_ACC;
            S_ACC: begin
                if (r_wtype == WT_BOHMAN) begin
                    n_state = r_bsin ? S_ROUND : S_MUL;
                end else if (r_k < win_terms(r_wtype)) begin
                    n_state = S_COSK;
                end else begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: n_state = S_SQ;
            S_SQ:    n_state = S_SUM;
            S_SUM:   n_state = S_CHK;
            S_CHK:   n_state = ((r_n == r_nn) && !w_zs) ? S_DIVW : S_DONE;
            S_DONE: begin
                if (w_room) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wtype       <= WT_RECT;
            r_wlen        <= LEN_W'(256);
            r_cnt         <= '0;
            r_csum        <= '0;
            r_ssum        <= '0;
            r_ovalid      <= 1'b0;
            r_dreq.start  <= 1'b0;
            r_creq.start  <= 1'b0;
        end else begin
            r_dreq.start <= 1'b0;
            r_creq.start <= 1'b0;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TYPE:   r_wtype <= i_cfg_data[TYPE_W-1:0];
                    CFG_LENGTH: r_wlen  <= i_cfg_data[LEN_W-1:0];
                    default:    r_wlen  <= r_wlen;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ll <= w_lc;
                        r_nn <= w_nnc;
                        if (i_restart || (r_cnt > w_nnc)) begin
                            r_n    <= '0;
                            r_csum <= '0;
                            r_ssum <= '0;
                        end else begin
                            r_n <= r_cnt;
                        end
                    end
                end
                S_SETUP: begin
                    r_d    <= w_d;
                    r_k    <= '0;
                    r_r    <= '0;
                    r_bsin <= 1'b0;
                    r_acc  <= $signed(win_base(r_wtype));
                    case (r_wtype)
                        WT_BARTLETT: begin
                            r_dreq <= '{1'b1, DIV_NW'(w_m) << 31, DIV_DW'(r_nn)};
                            r_purp <= P_DIRECT;
                        end
                        WT_TRIANG: begin
                            if (r_ll[0]) begin
                                r_dreq <= '{1'b1, (DIV_NW'(w_m) + DIV_NW'(1)) << 31,
                                            DIV_DW'(r_ll) + DIV_DW'(1)};
                            end else begin
                                r_dreq <= '{1'b1, (DIV_NW'({w_m, 1'b0}) + DIV_NW'(1)) << 30,
                                            DIV_DW'(r_ll)};
                            end
                            r_purp <= P_DIRECT;
                        end
                        WT_BARTHANN: begin
                            r_dreq <= '{1'b1, DIV_NW'(w_d) << 30, DIV_DW'({r_nn, 1'b0})};
                            r_purp <= P_LIN;
                        end
                        WT_BOHMAN: begin
                            r_dreq <= '{1'b1, DIV_NW'(w_d) << 30, DIV_DW'(r_nn)};
                            r_purp <= P_LIN;
                        end
                        default: r_purp <= P_DIRECT;
                    endcase
                end
                S_COSK: begin
                    r_r    <= w_rnew;
                    r_k    <= r_k + 3'd1;
                    r_dreq <= '{1'b1, DIV_NW'(w_rnew) << 32, DIV_DW'(r_nn)};
                    r_purp <= P_PH;
                end
                S_DIVW: begin
                    if (w_drsp.done) begin
                        case (r_purp)
                            P_DIRECT: r_acc <= $signed(w_drsp.quo[ACC_W-1:0]);
                            P_LIN: begin
                                if (r_wtype == WT_BARTHANN) begin
                                    r_cop <= $signed(BARTHANN_LIN);
                                    r_xop <= $signed(w_drsp.quo[CORD_W-1:0]);
                                    r_sub <= 1'b1;
                                end else begin
                                    r_a    <= w_drsp.quo[30:0];
                                    r_dreq <= '{1'b1, DIV_NW'(r_d) << 31, DIV_DW'(r_nn)};
                                    r_purp <= P_BPH;
                                end
                            end
                            P_BPH, P_PH: r_creq <= '{1'b1, w_drsp.quo[31:0]};
                            P_AMP: begin
                                r_amp  <= w_qsat;
                                r_dreq <= '{1'b1, DIV_NW'(1) << ENG_EXP, r_ssum};
                                r_purp <= P_ENG;
                            end
                            P_ENG:   r_eng <= w_qsat;
                            default: r_eng <= r_eng;
                        endcase
                    end
                end
                S_CORW: begin
                    if (w_crsp.done) begin
                        r_xop <= $signed(w_crsp.cosv);
                        if (r_wtype == WT_BOHMAN) begin
                            r_cop  <= $signed(CORD_W'(1 << 30) - CORD_W'(r_a));
                            r_sinv <= $signed(w_crsp.sinv);
                            r_sub  <= 1'b0;
                        end else begin
                            r_cop <= $signed(CORD_W'(w_wc[30:0]));
                            r_sub <= w_wc[31];
                        end
                    end
                end
                S_MUL: r_prod <= r_cop * r_xop;
                S_ACC: begin
                    r_acc <= r_sub ? (r_acc - w_q) : (r_acc + w_q);
                    if ((r_wtype == WT_BOHMAN) && !r_bsin) begin
                        r_bsin <= 1'b1;
                        r_cop  <= $signed(BOHMAN_SIN_C);
                        r_xop  <= r_sinv;
                        r_sub  <= 1'b0;
                    end
                end
                S_ROUND: r_coef <= w_sat;
                S_SQ: begin
                    r_sq   <= w_sqp;
                    r_csum <= r_csum + CSUM_W'(r_coef);
                end
                S_SUM: r_ssum <= r_ssum + SSUM_W'(r_sq);
                S_CHK: begin
                    r_last <= (r_n == r_nn);
                    r_zs   <= 1'b0;
                    r_amp  <= '0;
                    r_eng  <= '0;
                    if (r_n == r_nn) begin
                        if (w_zs) begin
                            r_zs  <= 1'b1;
                            r_amp <= '1;
                            r_eng <= '1;
                        end else begin
                            r_dreq <= '{1'b1, DIV_NW'(1) << AMP_EXP,
                                        DIV_DW'(r_csum[CSUM_W-2:0])};
                            r_purp <= P_AMP;
                        end
                    end
                end
                S_DONE: begin
                    if (w_room) begin
                        r_ovalid           <= 1'b1;
                        o_coefficient      <= r_coef;
                        o_sample_index     <= r_n;
                        o_last_sample      <= r_last;
                        o_amplitude_factor <= r_amp;
                        o_energy_factor    <= r_eng;
                        o_zero_sum         <= r_zs;
                        if (r_last) begin
                            r_cnt  <= '0;
                            r_csum <= '0;
                            r_ssum <= '0;
                        end else begin
                            r_cnt <= r_n + IDX_W'(1);
                        end
                    end
                end
                default: r_ovalid <= r_ovalid;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

`ifndef SYNTHESIS
    a_not_last_no_factors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_sample) |->
        (o_amplitude_factor == '0 && o_energy_factor == '0 && !o_zero_sum))
        else $error("factors set on a sample that is not last");

    a_zero_sum_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_sum) |->
        (o_amplitude_factor == '1 && o_energy_factor == '1))
        else $error("zero sum without saturated factors");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after an accepted transaction");
`endif

endmodule

[test/tb_window_coefficient_generator.sv]
module tb_window_coefficient_generator;
    import wcg_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam longint Q30_UNIT = 64'sd1073741824;
    localparam longint FACT_SAT = 64'hFFFFFFFF;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic [IDX_W-1:0]  idx;
        logic              last;
        logic [FACT_W-1:0] amp;
        logic [FACT_W-1:0] eng;
        logic              zs;
    } t_coef_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic                     i_restart;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [COEF_W-1:0] o_coefficient;
    logic [IDX_W-1:0]         o_sample_index;
    logic                     o_last_sample;
    logic [FACT_W-1:0]        o_amplitude_factor;
    logic [FACT_W-1:0]        o_energy_factor;
    logic                     o_zero_sum;
    logic                     i_cfg_we;
    logic                     i_cfg_index;
    logic [CFG_W-1:0]         i_cfg_data;

    window_coefficient_generator uut (.*);

    longint atan_step [CORD_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };

    logic [TYPE_W-1:0] win_type;
    logic [LEN_W-1:0]  win_len;
    int unsigned       next_index;
    logic [CSUM_W-1:0] coef_acc;
    logic [SSUM_W-1:0] sq_acc;

    t_coef_result expected_q[$];
    int unsigned  mismatches;
    int unsigned  cycles;
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint qmul(longint a, longint b);
        return (a * b + (Q30_UNIT >>> 1)) >>> 30;
    endfunction

    function automatic void rotate(input logic [31:0] p, output longint c,
                                   output longint s);
        longint z, x, y, dx, dy;
        bit neg;
        x = 652032875;
        y = 0;
        neg = 0;
        if (p >= 32'h40000000 && p < 32'hC0000000) begin
            z = longint'({32'b0, p}) - 64'sh80000000;
            neg = 1;
        end else if (p >= 32'hC0000000) begin
            z = longint'({32'b0, p}) - 64'sh100000000;
        end else begin
            z = longint'({32'b0, p});
        end
        for (int i = 0; i < CORD_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step[i];
            end else begin
                x += dx; y -= dy; z += atan_step[i];
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic longint cos_term(int unsigned k, int unsigned n, int unsigned nn);
        longint unsigned r;
        longint c, s;
        r = (longint'(k) * n) % nn;
        rotate(32'((r << 32) / nn), c, s);
        return c;
    endfunction

    function automatic longint shape_q30(int unsigned n, int unsigned nn, int unsigned ll);
        int unsigned m;
        longint unsigned d;
        longint a, c, s;
        m = (n < nn - n) ? n : nn - n;
        d = (2 * n >= nn) ? 2 * n - nn : nn - 2 * n;
        case (win_type)
            WT_BARTHANN: begin
                a = (d << 30) / (2 * longint'(nn));
                return 665719931 - qmul(515396076, a) - qmul(408021893, cos_term(1, n, nn));
            end
            WT_BARTLETT: return (longint'(2 * m) << 30) / nn;
            WT_BLACKMAN: return 450971566 - qmul(536870912, cos_term(1, n, nn))
                                + qmul(85899346, cos_term(2, n, nn));
            WT_BHARRIS: return 385204879 - qmul(524297395, cos_term(1, n, nn))
                               + qmul(151698245, cos_term(2, n, nn))
                               - qmul(12541305, cos_term(3, n, nn));
            WT_BOHMAN: begin
                a = (d << 30) / nn;
                rotate(32'((d << 31) / nn), c, s);
                return qmul(Q30_UNIT - a, c) + qmul(341782638, s);
            end
            WT_FLATTOP: return 231476135 - qmul(447354753, cos_term(1, n, nn))
                               + qmul(297709049, cos_term(2, n, nn))
                               - qmul(89742211, cos_term(3, n, nn))
                               + qmul(7459680, cos_term(4, n, nn));
            WT_HAMMING: return 579820585 - qmul(493921239, cos_term(1, n, nn));
            WT_HANN: return 536870912 - qmul(536870912, cos_term(1, n, nn));
            WT_NUTTALL: return 390393092 - qmul(525250341, cos_term(1, n, nn))
                               + qmul(146672596, cos_term(2, n, nn))
                               - qmul(11425794, cos_term(3, n, nn));
            WT_RECT: return Q30_UNIT;
            WT_TRIANG: begin
                if (ll % 2 == 1)
                    return (longint'(2 * (m + 1)) << 30) / (ll + 1);
                return (longint'(2 * m + 1) << 30) / ll;
            end
            default: return 0;
        endcase
    endfunction

    task automatic predict_coefficient(input bit restart);
        int unsigned ll, nn, n;
        longint v, csum, q;
        t_coef_result r;
        ll = win_len;
        if (ll < 2) ll = 2;
        if (ll > MAX_LENGTH) ll = MAX_LENGTH;
        nn = ll - 1;
        if (restart || next_index > nn) begin
            next_index = 0;
            coef_acc = '0;
            sq_acc = '0;
        end
        n = next_index;
        v = (shape_q30(n, nn, ll) + (64'sd1 << (Q_SHIFT - 1))) >>> Q_SHIFT;
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        coef_acc = coef_acc + CSUM_W'(v);
        sq_acc = sq_acc + SSUM_W'(v * v);
        r = '0;
        r.coef = COEF_W'(v);
        r.idx = IDX_W'(n);
        r.last = (n == nn);
        if (r.last) begin
            csum = longint'($signed(coef_acc));
            if (csum <= 0 || sq_acc == 0) begin
                r.zs = 1'b1;
                r.amp = '1;
                r.eng = '1;
            end else begin
                q = longint'((64'd1 << AMP_EXP) / csum);
                r.amp = (q > FACT_SAT) ? '1 : FACT_W'(q);
                q = longint'((64'd1 << ENG_EXP) / {19'b0, sq_acc});
                r.eng = (q > FACT_SAT) ? '1 : FACT_W'(q);
            end
            next_index = 0;
            coef_acc = '0;
            sq_acc = '0;
        end else begin
            next_index = n + 1;
        end
        expected_q.push_back(r);
    endtask

    task automatic send_item(input bit restart);
        i_valid <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (!o_ready);
        predict_coefficient(restart);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            i_restart <= $urandom_range(1);
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic write_config(input logic [TYPE_W-1:0] t, input logic [LEN_W-1:0] len);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_TYPE;
        i_cfg_data <= CFG_W'(t);
        @(posedge i_clk);
        win_type = t;
        i_cfg_index <= CFG_LENGTH;
        i_cfg_data <= len;
        @(posedge i_clk);
        win_len = len;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained;
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic run_window(input int unsigned count);
        for (int i = 0; i < count; i++) send_item(i == 0);
    endtask

    always @(posedge i_clk) begin
        t_coef_result exp_r, got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("window_coefficient_generator test failed");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_coefficient, o_sample_index, o_last_sample,
                   o_amplitude_factor, o_energy_factor, o_zero_sum};
            if (expected_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected transaction: %p", got);
                mismatches++;
            end else begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r) begin
                    if (mismatches < 10)
                        $display("mismatch: expected %p, got %p", exp_r, got);
                    mismatches++;
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_reset_defaults;
        run_window(3);
        send_item(1'b0);
        send_item(1'b1);
        wait_drained();
    endtask

    task automatic test_every_type;
        for (int t = 0; t < 16; t++) begin
            write_config(TYPE_W'(t), (t % 2) ? 13'd4 : 13'd3);
            run_window((t % 2) ? 4 : 3);
            wait_drained();
        end
    endtask

    task automatic test_length_edges;
        write_config(WT_HANN, 13'd0);
        run_window(3);
        wait_drained();
        write_config(WT_TRIANG, 13'd1);
        run_window(2);
        wait_drained();
        write_config(WT_TRIANG, 13'd2);
        run_window(2);
        wait_drained();
        write_config(WT_BARTLETT, 13'd2);
        run_window(2);
        wait_drained();
        write_config(WT_BOHMAN, 13'd8191);
        run_window(5);
        wait_drained();
        write_config(WT_BOHMAN, 13'd3);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b1);
        wait_drained();
    endtask

    task automatic test_long_window;
        write_config(WT_RECT, 13'd640);
        run_window(640);
        wait_drained();
    endtask

    task automatic test_random(input int unsigned items, input int unsigned idle,
                               input int unsigned stall);
        int unsigned sent, len, count;
        logic [TYPE_W-1:0] t;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        sent = 0;
        while (sent < items) begin
            t = ($urandom_range(9) == 0) ? TYPE_W'($urandom_range(11, 15))
                                         : TYPE_W'($urandom_range(0, 10));
            len = ($urandom_range(15) == 0) ? $urandom_range(25, 120) : $urandom_range(2, 20);
            if ($urandom_range(30) == 0)
                len = $urandom_range(0, 1);
            if (sent != 0 && $urandom_range(7) == 0)
                write_config(t, LEN_W'(len));
            else if (sent == 0 || $urandom_range(3) != 0)
                write_config(t, LEN_W'(len));
            count = (len < 2) ? 2 : len;
            if ($urandom_range(5) == 0) begin
                count = $urandom_range(1, count + 3);
                for (int i = 0; i < count; i++) send_item($urandom_range(4) == 0);
            end else begin
                run_window(count);
            end
            sent += count;
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_restart = 1'b0;
        i_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_TYPE;
        i_cfg_data = '0;
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        win_type = WT_RECT;
        win_len = 13'd256;
        next_index = 0;
        coef_acc = '0;
        sq_acc = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_every_type();
        test_length_edges();
        test_long_window();
        test_random(175, 0, 0);
        test_random(175, 59, 0);
        test_random(175, 0, 59);
        test_random(175, 32, 32);

        wait_drained();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("window_coefficient_generator test passed");
        else
            $display("window_coefficient_generator test failed");
        $finish;
    end

endmodule
